/* design/sorted_priority_queue_defines.svh */
// assertion helpers for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// implication checked at every clock edge outside reset
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain condition that must hold at every clock edge outside reset
`define SPQ_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

/* design/spq_pkg.sv */
`default_nettype none

package spq_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 4;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [StatusW-1:0]       status_t;
  typedef logic [OccW-1:0]          occ_t;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // status codes
  localparam status_t STATUS_DONE      = 2'd0;
  localparam status_t STATUS_FULL      = 2'd1;
  localparam status_t STATUS_EMPTY     = 2'd2;

  // control broadcast to every cell
  typedef struct packed {
    logic load;
    logic remove;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* design/spq_in_if.sv */
`default_nettype none

interface spq_in_if;
  logic            valid;
  logic            ready;
  logic            command;
  spq_pkg::value_t value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

/* design/spq_out_if.sv */
`default_nettype none

interface spq_out_if;
  logic             valid;
  logic             ready;
  spq_pkg::status_t status;
  spq_pkg::value_t  removed_value;
  spq_pkg::value_t  largest;
  spq_pkg::value_t  smallest;
  spq_pkg::occ_t    occupancy;
  logic             is_empty;

  modport source (output valid, output status, output removed_value, output largest,
                  output smallest, output occupancy, output is_empty, input ready);
  modport sink   (input valid, input status, input removed_value, input largest,
                  input smallest, input occupancy, input is_empty, output ready);
endinterface

`default_nettype wire

/* design/sorted_priority_queue.sv */
// Sorted priority queue, largest value first.
// in_ch carries one command word: insert value (command 0) or remove the
// largest (command 1). out_ch returns one report word per command: status,
// the removed value, largest and smallest after the command, occupancy and
// an empty flag. Both channels use valid/ready; a word moves when both high.
// The store is a row of DEPTH compare-and-shift cells. Every cell compares
// the incoming value with its own entry in parallel and takes its own,
// the new or its neighbor's entry, so the cells take an insert or remove
// in the cycle it is accepted, whatever the fill level.
// After a command is accepted, its result passes the stage register and then the output register.
// Throughput: one command per cycle while out_ch takes reports; a stage
// register and the output register sit between the cells and out_ch, so
// the block holds up to two finished reports before in_ch.ready drops.
// Reset (rst_n low, synchronous) empties the queue and drops pending
// reports. Equal values leave in arrival order. A full insert or empty
// remove changes nothing and reports the reject status.
`default_nettype none
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;

  logic    s1_valid_r;
  logic    s1_valid_nxt;
  status_t s1_status_r;
  value_t  s1_removed_r;

  logic    out_valid_r;
  logic    out_valid_nxt;
  status_t out_status_r;
  value_t  out_removed_r;
  value_t  out_largest_r;
  value_t  out_smallest_r;
  occ_t    out_occ_r;
  logic    out_empty_r;

  logic      in_acc;
  logic      advance;
  logic      is_full;
  logic      is_empt;
  logic      reject;
  status_t   step_status;
  cell_ctl_t ctl;

  value_t           cell_entry [DEPTH];
  logic [DEPTH-1:0] cell_ge;
  logic [DEPTH-1:0] cell_occ;
  logic [DEPTH-1:0] cell_tail;

  value_t            tail_value;
  logic [CntW+3:0]   count_ext;

  // handshake
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // reject checks against the current fill level
  assign is_full = (count_r == CntW'(DEPTH));
  assign is_empt = (count_r == '0);
  assign reject  = (in_ch.command == CMD_INSERT) ? is_full : is_empt;

  always_comb begin
    unique case (in_ch.command)
      CMD_INSERT: step_status = is_full ? STATUS_FULL  : STATUS_DONE;
      CMD_REMOVE: step_status = is_empt ? STATUS_EMPTY : STATUS_DONE;
      default:    step_status = STATUS_DONE;
    endcase
  end

  assign ctl.load   = in_acc && !reject;
  assign ctl.remove = (in_ch.command == CMD_REMOVE);

  // fill level
  always_comb begin
    count_nxt = count_r;
    if (ctl.load) begin
      if (ctl.remove) begin
        count_nxt = count_r - CntW'(1);
      end else begin
        count_nxt = count_r + CntW'(1);
      end
    end
  end

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   prev_ge;
    value_t prev_entry;
    value_t next_entry;

    assign cell_occ[i]  = (count_r > CntW'(i));
    assign cell_tail[i] = (count_r == CntW'(i + 1));

    if (i == 0) begin : g_head
      assign prev_ge    = 1'b1;
      assign prev_entry = in_ch.value;
    end else begin : g_body
      assign prev_ge    = cell_ge[i-1];
      assign prev_entry = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_entry = cell_entry[i];
    end else begin : g_mid
      assign next_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .value      (in_ch.value),
      .occupied   (cell_occ[i]),
      .prev_ge    (prev_ge),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .entry      (cell_entry[i]),
      .ge         (cell_ge[i])
    );
  end

  // pick the rear entry by its one-hot tail flag
  always_comb begin
    tail_value = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      tail_value = tail_value | (cell_tail[i] ? cell_entry[i] : '0);
    end
  end

  assign count_ext = (CntW + 4)'(count_r);

  // stage and output valid flags
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_valid_r && advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // step result held until the report is built
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_status_r  <= step_status;
      s1_removed_r <= (ctl.load && ctl.remove) ? cell_entry[0] : '0;
    end
  end

  // report from the state the step left behind
  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      out_status_r   <= s1_status_r;
      out_removed_r  <= s1_removed_r;
      out_largest_r  <= cell_occ[0] ? cell_entry[0] : '0;
      out_smallest_r <= tail_value;
      out_occ_r      <= count_ext[OccW-1:0];
      out_empty_r    <= !cell_occ[0];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.removed_value = out_removed_r;
  assign out_ch.largest       = out_largest_r;
  assign out_ch.smallest      = out_smallest_r;
  assign out_ch.occupancy     = out_occ_r;
  assign out_ch.is_empty      = out_empty_r;

  `SPQ_ALWAYS(a_count_bound, count_r <= CntW'(DEPTH), "fill level beyond depth")
  `SPQ_ASSERT(a_insert_grows, in_acc && !ctl.remove && !is_full |=> count_r == $past(count_r) + CntW'(1), "insert did not grow the queue")
  `SPQ_ASSERT(a_empty_reject, in_acc && ctl.remove && is_empt |=> s1_status_r == STATUS_EMPTY && count_r == '0, "empty remove not rejected")
  `SPQ_ASSERT(a_no_drop, s1_valid_r && !advance |=> s1_valid_r && $stable(s1_status_r), "pending step lost")

endmodule

`default_nettype wire

/* design/spq_cell.sv */
`default_nettype none

module spq_cell (
  input  wire logic              clk,
  input  wire spq_pkg::cell_ctl_t ctl,
  input  wire spq_pkg::value_t   value,
  input  wire logic              occupied,
  input  wire logic              prev_ge,
  input  wire spq_pkg::value_t   prev_entry,
  input  wire spq_pkg::value_t   next_entry,
  output spq_pkg::value_t        entry,
  output logic                   ge
);
  import spq_pkg::*;

  value_t entry_r;
  value_t entry_nxt;

  // this entry stays ahead of the new word
  assign ge    = occupied && (entry_r >= value);
  assign entry = entry_r;

  // remove shifts toward the front, insert shifts toward the rear
  always_comb begin
    priority if (ctl.remove) begin
      entry_nxt = next_entry;
    end else if (ge) begin
      entry_nxt = entry_r;
    end else if (prev_ge) begin
      entry_nxt = value;
    end else begin
      entry_nxt = prev_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

`default_nettype wire
